/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: assertion failed");

// A condition in one cycle that implies another in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst, cond, conseq) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error("%m: assertion failed");

`endif

/* rtl/tle_pkg.sv */
// ----------------------------------------------------------------------------
// tle_pkg
// Types and constants shared by the terminal line editor and its checker.
// ----------------------------------------------------------------------------
package tle_pkg;

   localparam int CHAR_W  = 8;
   localparam int CAP_W   = 7;
   localparam int LEN_W   = 6;
   localparam int STORE_W = 7;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CH_DEL   = 8'd127;
   localparam logic [CHAR_W-1:0] CH_FIRST = 8'd32;
   localparam logic [CHAR_W-1:0] CH_LAST  = 8'd126;

   localparam logic KIND_ECHO = 1'b0;
   localparam logic KIND_LINE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } tle_state_type;

endpackage

/* rtl/tle_ram.sv */
// ----------------------------------------------------------------------------
// tle_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/terminal_line_editor.sv */
// ----------------------------------------------------------------------------
// terminal_line_editor
// Line editor for a character terminal: stores printable characters, handles
// backspace, echoes, and reads the completed line out on carriage return or
// line feed.
//
//   channel | direction | ports            | content
//   --------+-----------+------------------+-------------------------------
//   req     | in        | valid/ready      | received character
//   rsp     | out       | valid/ready      | echo or line character
//   csr     | in        | write enable     | line capacity
//
// The result of an ordinary character sits in the output register while the
// next character may already be taken.
// A line end of n characters occupies n + 1 results; the store is read one
// entry per cycle through the RAM's registered read port, so the readout runs
// at one character per cycle while the output is taken.
// No character is accepted during a readout, which keeps writes of the next
// line away from entries still being read.
// Reset clears the length, the state and the output valid; the capacity
// returns to 64. The line store itself is not cleared.
// ----------------------------------------------------------------------------
module terminal_line_editor #(
   parameter int BUFFER_DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_char,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_kind,
   output logic [7:0] rsp_out_char,
   output logic [5:0] rsp_line_length,
   output logic       rsp_last,
   input  logic       csr_wr_en,
   input  logic [6:0] csr_wr_data
);

   import tle_pkg::*;

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam logic [CAP_W-1:0] DEPTH_CAP = CAP_W'(BUFFER_DEPTH);

   tle_state_type state_ff, state_in;

   logic [CAP_W-1:0]  cap_ff;
   logic [CAP_W-1:0]  eff_cap;
   logic [AW-1:0]     len_ff, len_in;
   logic [AW-1:0]     cnt_ff, cnt_in;
   logic [AW-1:0]     idx_ff, idx_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kind_ff, rsp_kind_in;
   logic [CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic [LEN_W-1:0]  rsp_len_ff, rsp_len_in;
   logic              rsp_last_ff, rsp_last_in;

   logic               slot_free;
   logic               accept;
   logic               ram_wr_en;
   logic               ram_rd_en;
   logic [AW-1:0]      ram_rd_addr;
   logic [STORE_W-1:0] ram_rd_data;

   tle_ram #(
      .WIDTH (STORE_W),
      .DEPTH (BUFFER_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (len_ff),
      .wr_data (req_rx_char[STORE_W-1:0]),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // A capacity of zero behaves as one; values above the store size saturate.
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CAP_W'(1);
      end else if (cap_ff > DEPTH_CAP) begin
         eff_cap = DEPTH_CAP;
      end else begin
         eff_cap = cap_ff;
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_last_in  = rsp_last_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_rx_char == CH_CR || req_rx_char == CH_LF) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_ECHO;
                  rsp_char_in  = CH_LF;
                  rsp_len_in   = LEN_W'(len_ff);
                  rsp_last_in  = (len_ff == '0);
                  len_in       = '0;
                  if (len_ff != '0) begin
                     // Fetch the first character while the echo goes out.
                     cnt_in      = len_ff;
                     idx_in      = '0;
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = '0;
                     state_in    = ST_READ;
                  end
               end else if (req_rx_char == CH_BS || req_rx_char == CH_DEL) begin
                  if (len_ff != '0) begin
                     len_in       = AW'(len_ff - 1'b1);
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_ECHO;
                     rsp_char_in  = CH_BS;
                     rsp_len_in   = '0;
                     rsp_last_in  = 1'b1;
                  end
               end else if (req_rx_char inside {[CH_FIRST:CH_LAST]}) begin
                  if ((CAP_W'(len_ff) + CAP_W'(1)) < eff_cap) begin
                     ram_wr_en    = 1'b1;
                     len_in       = AW'(len_ff + 1'b1);
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_ECHO;
                     rsp_char_in  = req_rx_char;
                     rsp_len_in   = '0;
                     rsp_last_in  = 1'b1;
                  end
               end
            end
         end
         ST_READ: begin
            // The RAM output holds entry idx_ff until the next read is issued.
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_LINE;
               rsp_char_in  = {1'b0, ram_rd_data};
               rsp_len_in   = LEN_W'(cnt_ff);
               rsp_last_in  = (idx_ff == AW'(cnt_ff - 1'b1));
               if (idx_ff == AW'(cnt_ff - 1'b1)) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in      = AW'(idx_ff + 1'b1);
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = AW'(idx_ff + 1'b1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= CAP_RESET;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      rsp_char_ff <= rsp_char_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_out_char    = rsp_char_ff;
   assign rsp_line_length = rsp_len_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

/* rtl/tle_checker.sv */
// ----------------------------------------------------------------------------
// tle_checker
// Port-level checks on the terminal line editor, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tle_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_kind,
   input logic [7:0] rsp_out_char,
   input logic [5:0] rsp_line_length,
   input logic       rsp_last
);

   import tle_pkg::*;

   // A stalled result transaction stays valid and keeps its character, kind and last flag.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_char) && $stable(rsp_kind) && $stable(rsp_last))

   // The editor takes no character while its output register is blocked.
   `ASSERT_ALWAYS(a_no_accept_when_full, clock, reset, (rsp_valid && !rsp_ready) |-> !req_ready)

   // Line characters only come from a non-empty line and are printable.
   `ASSERT_ALWAYS(a_line_nonzero, clock, reset, (rsp_valid && rsp_kind == KIND_LINE) |-> (rsp_line_length != 6'd0 && rsp_out_char >= CH_FIRST && rsp_out_char <= CH_LAST))

   // A character echo or a backspace echo is a single result with no length.
   `ASSERT_ALWAYS(a_echo_single, clock, reset, (rsp_valid && rsp_kind == KIND_ECHO && rsp_out_char != CH_LF) |-> (rsp_last && rsp_line_length == 6'd0))

   // While a line is read out, no new character is taken.
   `ASSERT_ALWAYS(a_readout_blocks, clock, reset, (rsp_valid && rsp_kind == KIND_LINE && !rsp_last) |-> !req_ready)

endmodule

bind terminal_line_editor tle_checker u_tle_checker (.*);

/* tb/sv/terminal_line_editor_tb.sv */
// ----------------------------------------------------------------------------
// terminal_line_editor_tb
// Self-checking testbench for the terminal line editor. A short table of
// directed characters covers the capacity extremes, backspace and delete,
// ignored bytes and empty lines. Random lines follow: printable text with
// edits, noise and line ends, under several capacities. Typed table rows
// carry their expected result; a line mirror predicts all other echo and
// readout transactions, compared in order. Both channels stall at random.
// ----------------------------------------------------------------------------
module terminal_line_editor_tb;
   import tle_pkg::*;

   localparam int BUFFER_DEPTH  = 64;
   localparam int RANDOM_ITEMS  = 200;
   localparam int STALL_LIMIT   = 1000;
   localparam int SETTLE_CYCLES = 4;
   localparam int END_CYCLES    = 20;

   typedef struct packed {
      logic              kind;
      logic [CHAR_W-1:0] ch;
      logic [LEN_W-1:0]  len;
      logic              last;
   } line_out_type;

   typedef struct packed {
      logic              set_cap;
      logic [CAP_W-1:0]  cap;
      logic [CHAR_W-1:0] ch;
      logic              typed;
      logic              has_out;
      line_out_type      out;
   } dir_row_type;

   localparam line_out_type NO_OUT = '0;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [CHAR_W-1:0] req_rx_char = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_kind;
   logic [7:0]        rsp_out_char;
   logic [5:0]        rsp_line_length;
   logic              rsp_last;
   logic              csr_wr_en = 1'b0;
   logic [CAP_W-1:0]  csr_wr_data = '0;

   // Mirror of the line state.
   logic [STORE_W-1:0] line_mirror [BUFFER_DEPTH];
   logic [CAP_W-1:0]   line_count = '0;
   logic [CAP_W-1:0]   line_cap = CAP_RESET;

   line_out_type line_out_q [$];
   int           fail_count = 0;
   int           stall_cycles = 0;
   bit           calm = 1'b0;

   logic [CAP_W-1:0] cap_sweep [5] = '{7'd0, 7'd127, 7'd1, 7'd64, 7'd2};

   dir_row_type dir_tab [24] = '{
      '{1'b0, 7'd0,   CH_LF,    1'b1, 1'b1, '{KIND_ECHO, CH_LF, 6'd0, 1'b1}},
      '{1'b0, 7'd0,   CH_BS,    1'b1, 1'b0, NO_OUT},
      '{1'b0, 7'd0,   CH_DEL,   1'b1, 1'b0, NO_OUT},
      '{1'b0, 7'd0,   8'h00,    1'b1, 1'b0, NO_OUT},
      '{1'b0, 7'd0,   8'hFF,    1'b1, 1'b0, NO_OUT},
      '{1'b0, 7'd0,   8'h1F,    1'b1, 1'b0, NO_OUT},
      '{1'b0, 7'd0,   CH_FIRST, 1'b1, 1'b1, '{KIND_ECHO, CH_FIRST, 6'd0, 1'b1}},
      '{1'b0, 7'd0,   CH_LAST,  1'b1, 1'b1, '{KIND_ECHO, CH_LAST, 6'd0, 1'b1}},
      '{1'b0, 7'd0,   CH_DEL,   1'b1, 1'b1, '{KIND_ECHO, CH_BS, 6'd0, 1'b1}},
      '{1'b0, 7'd0,   8'h41,    1'b1, 1'b1, '{KIND_ECHO, 8'h41, 6'd0, 1'b1}},
      '{1'b0, 7'd0,   CH_CR,    1'b0, 1'b0, NO_OUT},
      // A capacity of zero keeps nothing.
      '{1'b1, 7'd0,   8'h42,    1'b1, 1'b0, NO_OUT},
      '{1'b0, 7'd0,   CH_LF,    1'b1, 1'b1, '{KIND_ECHO, CH_LF, 6'd0, 1'b1}},
      '{1'b1, 7'd1,   8'h43,    1'b1, 1'b0, NO_OUT},
      '{1'b1, 7'd2,   8'h44,    1'b1, 1'b1, '{KIND_ECHO, 8'h44, 6'd0, 1'b1}},
      '{1'b0, 7'd0,   8'h45,    1'b1, 1'b0, NO_OUT},
      '{1'b0, 7'd0,   CH_CR,    1'b0, 1'b0, NO_OUT},
      '{1'b1, 7'd127, 8'h61,    1'b0, 1'b0, NO_OUT},
      '{1'b0, 7'd0,   8'h62,    1'b0, 1'b0, NO_OUT},
      // Capacity lowered to the current length: new text is dropped.
      '{1'b1, 7'd2,   8'h63,    1'b1, 1'b0, NO_OUT},
      '{1'b0, 7'd0,   CH_BS,    1'b1, 1'b1, '{KIND_ECHO, CH_BS, 6'd0, 1'b1}},
      '{1'b0, 7'd0,   CH_BS,    1'b1, 1'b1, '{KIND_ECHO, CH_BS, 6'd0, 1'b1}},
      '{1'b0, 7'd0,   8'h64,    1'b1, 1'b1, '{KIND_ECHO, 8'h64, 6'd0, 1'b1}},
      '{1'b0, 7'd0,   CH_LF,    1'b0, 1'b0, NO_OUT}
   };

   terminal_line_editor #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_char    (req_rx_char),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_out_char   (rsp_out_char),
      .rsp_line_length(rsp_line_length),
      .rsp_last       (rsp_last),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Updates the line mirror for one accepted character and, when asked,
   // queues the transactions it causes.
   task automatic editor_predict(input logic [CHAR_W-1:0] c, input bit push);
      logic [CAP_W-1:0] cap;
      logic [CAP_W-1:0] n;
      line_out_type     r;
      cap = line_cap;
      if (cap == 0) cap = CAP_W'(1);
      else if (cap > BUFFER_DEPTH) cap = CAP_W'(BUFFER_DEPTH);
      if (c == CH_CR || c == CH_LF) begin
         n = (line_count > BUFFER_DEPTH - 1) ? CAP_W'(BUFFER_DEPTH - 1) : line_count;
         r.kind = KIND_ECHO;
         r.ch   = CH_LF;
         r.len  = n[LEN_W-1:0];
         r.last = (n == 0);
         if (push) line_out_q.push_back(r);
         for (int i = 0; i < n; i++) begin
            r.kind = KIND_LINE;
            r.ch   = {1'b0, line_mirror[i]};
            r.last = (i + 1 == n);
            if (push) line_out_q.push_back(r);
         end
         line_count = '0;
      end else if (c == CH_BS || c == CH_DEL) begin
         if (line_count != 0) begin
            line_count = line_count - 1'b1;
            r = '{KIND_ECHO, CH_BS, 6'd0, 1'b1};
            if (push) line_out_q.push_back(r);
         end
      end else if (c >= CH_FIRST && c <= CH_LAST && line_count + 1 < cap) begin
         line_mirror[line_count[LEN_W-1:0]] = c[STORE_W-1:0];
         line_count = line_count + 1'b1;
         r = '{KIND_ECHO, c, 6'd0, 1'b1};
         if (push) line_out_q.push_back(r);
      end
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 8);
      return $urandom_range(15, 40);
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   task automatic send_char(input logic [CHAR_W-1:0] c, input bit push);
      int gap;
      gap = (calm || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   = 1'b1;
      req_rx_char = c;
      do @(posedge clock); while (!req_ready);
      editor_predict(c, push);
   endtask

   // Holds the sender off until every queued transaction has come out, then
   // gives the block time to settle.
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (line_out_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      wait_drained();
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      line_cap  = value;
   endtask

   // Receiver: random stalls, suspended while the sender runs calm.
   initial begin
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_ready = 1'b0;
            hold--;
         end else begin
            rsp_ready = 1'b1;
            if (!calm && $urandom_range(0, 3) == 0) hold = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      line_out_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (line_out_q.size() == 0) begin
            $error("unexpected rsp transaction: kind %0d, char %0h",
                   rsp_kind, rsp_out_char);
            fail_count++;
         end else begin
            want = line_out_q.pop_front();
            check_field("kind", want.kind, rsp_kind);
            check_field("out_char", want.ch, rsp_out_char);
            check_field("line_length", want.len, rsp_line_length);
            check_field("last", want.last, rsp_last);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles == STALL_LIMIT) begin
            $error("no transaction for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      int unsigned      rand_items;
      int unsigned      phase;
      int unsigned      run_len;
      int unsigned      lines;
      logic [CHAR_W-1:0] c;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int k = 0; k < $size(dir_tab); k++) begin
         if (dir_tab[k].set_cap) write_capacity(dir_tab[k].cap);
         if (dir_tab[k].typed && dir_tab[k].has_out) line_out_q.push_back(dir_tab[k].out);
         send_char(dir_tab[k].ch, !dir_tab[k].typed);
      end

      rand_items = 0;
      phase      = 0;
      while (rand_items < RANDOM_ITEMS) begin
         if (phase < $size(cap_sweep)) write_capacity(cap_sweep[phase]);
         else write_capacity(CAP_W'($urandom_range(0, 127)));
         phase++;
         calm  = ($urandom_range(0, 3) == 0);
         lines = $urandom_range(2, 4);
         for (int l = 0; l < lines; l++) begin
            if ($urandom_range(0, 9) == 0) begin
               // Broken line: raw bytes and no line end, so the next phase
               // may change the capacity in the middle of a line.
               run_len = $urandom_range(1, 6);
               for (int i = 0; i < run_len; i++) begin
                  send_char(CHAR_W'($urandom_range(0, 255)), 1'b1);
               end
            end else begin
               run_len = ($urandom_range(0, 11) == 0) ? $urandom_range(40, 70)
                                                      : $urandom_range(0, 8);
               for (int i = 0; i < run_len; i++) begin
                  case ($urandom_range(0, 19))
                     0:       c = CH_BS;
                     1:       c = CH_DEL;
                     2:       c = CHAR_W'($urandom_range(0, 255));
                     default: c = CHAR_W'($urandom_range(CH_FIRST, CH_LAST));
                  endcase
                  send_char(c, 1'b1);
                  rand_items++;
               end
               send_char($urandom_range(0, 1) ? CH_CR : CH_LF, 1'b1);
               rand_items++;
            end
            if ($urandom_range(0, 7) == 0) wait_drained();
         end
      end

      calm = 1'b0;
      wait_drained();
      repeat (END_CYCLES) @(posedge clock);
      if (line_out_q.size() != 0) begin
         $error("%0d expected rsp transactions never arrived", line_out_q.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
